/* rtl/msr_pkg.sv */
package msr_pkg;

	// Field widths of the streams and registers.
	localparam int OP_W   = 2;
	localparam int TIME_W = 32;
	localparam int POT_W  = 10;
	localparam int DUTY_W = 8;
	localparam int LEN_W  = 16;
	localparam int REG_W  = 16;

	// Scale constants.
	localparam int DUTY_MAX = 255;
	localparam int POT_MAX  = 1023;

	// Reset values of the registers and state.
	localparam int RAMP_MIN_RST = 1000;
	localparam int RAMP_MAX_RST = 10000;
	localparam int RAMP_LEN_RST = 1000;

	// Serial multiply-divide unit: floor(a * b / d).
	localparam int A_W   = (POT_W > DUTY_W) ? POT_W : DUTY_W;
	localparam int B_W   = LEN_W;
	localparam int D_W   = LEN_W;
	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(P_W);

	// Button events.
	localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
	localparam logic [OP_W-1:0] OP_START = 2'd2;

	// Configuration port.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_RAMP_MIN = 1'b0;
	localparam logic REG_RAMP_MAX = 1'b1;

	typedef struct packed {
		logic [A_W-1:0] a;
		logic [B_W-1:0] b;
		logic [D_W-1:0] d;
	} md_req_t;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [TIME_W-1:0] now_ms;
		logic [POT_W-1:0]  speed_pot;
		logic [POT_W-1:0]  ramp_pot;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] pwm_duty;
		logic              running;
		logic              ramping;
	} out_item_t;

	typedef struct packed {
		logic [REG_W-1:0] ramp_min_ms;
		logic [REG_W-1:0] ramp_max_ms;
	} ramp_cfg_t;

endpackage

/* rtl/msr_muldiv.sv */
module msr_muldiv (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  msr_pkg::md_req_t     req,
	output logic                 done,
	output logic [msr_pkg::P_W-1:0] q
);
	import msr_pkg::*;

	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [D_W-1:0]   d_q;
	logic [P_W-1:0]   acc_q;
	logic [D_W-1:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             div_q;
	logic             dz_q;
	logic             done_q;

	logic [D_W:0]     rem_sh;
	logic             q_bit;
	logic [D_W:0]     rem_sub;

	// One restoring division step: bring down the next dividend bit.
	always_comb begin
		rem_sh  = {rem_q, acc_q[P_W-1]};
		rem_sub = rem_sh - {1'b0, d_q};
		q_bit   = (rem_sh >= {1'b0, d_q});
	end

	// Control: multiply phase over the bits of a, then divide phase over the product bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				div_q  <= 1'b0;
				cnt_q  <= CNT_W'(A_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					if (div_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						div_q <= 1'b1;
						cnt_q <= CNT_W'(P_W - 1);
					end
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: one bit of the multiplier or one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			d_q   <= req.d;
			dz_q  <= (req.d == '0);
			acc_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!div_q) begin
				acc_q <= {acc_q[P_W-2:0], 1'b0} + (a_q[A_W-1] ? P_W'(b_q) : '0);
				a_q   <= {a_q[A_W-2:0], 1'b0};
			end else begin
				acc_q <= {acc_q[P_W-2:0], q_bit};
				rem_q <= q_bit ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
			end
		end
	end

	// A zero divisor only occurs with a zero product; the result is then zero.
	assign q    = dz_q ? '0 : acc_q;
	assign done = done_q;

endmodule

/* rtl/msr_core.sv */
module msr_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  msr_pkg::in_item_t   in_item,
	input  msr_pkg::ramp_cfg_t  cfg,
	output logic                res_valid,
	input  logic                res_ready,
	output msr_pkg::out_item_t  res
);
	import msr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_TGT  = 3'd2;
	localparam logic [2:0] ST_RLEN = 3'd3;
	localparam logic [2:0] ST_DUTY = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]        state_q;
	logic              run_q;
	logic              ramp_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] now_q;
	logic [POT_W-1:0]  spd_q;
	logic [POT_W-1:0]  rmp_q;
	logic [DUTY_W-1:0] target_q;
	logic [LEN_W-1:0]  len_q;
	logic [DUTY_W-1:0] duty_q;

	logic              accept;
	logic [POT_W-1:0]  spd_sat;
	logic [POT_W-1:0]  rmp_sat;
	logic [TIME_W-1:0] elapsed;
	logic              elapsed_le;
	logic              cfg_inverted;
	logic              eval_tgt;
	logic              eval_duty;
	logic              tgt_to_rlen;
	logic              md_start;
	md_req_t           md_req;
	logic              md_done;
	logic [P_W-1:0]    md_q;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	// Pot readings above full scale saturate.
	assign spd_sat = (32'(in_item.speed_pot) > POT_MAX) ? POT_W'(POT_MAX) : in_item.speed_pot;
	assign rmp_sat = (32'(in_item.ramp_pot) > POT_MAX) ? POT_W'(POT_MAX) : in_item.ramp_pot;

	// Ramp progress, modulo the time width.
	assign elapsed      = now_q - start_q;
	assign elapsed_le   = (elapsed <= TIME_W'(len_q));
	assign cfg_inverted = (cfg.ramp_max_ms < cfg.ramp_min_ms);

	// Points where a multiply-divide is launched.
	assign eval_tgt    = (state_q == ST_EVAL) && !run_q;
	assign eval_duty   = (state_q == ST_EVAL) && run_q && ramp_q && elapsed_le;
	assign tgt_to_rlen = (state_q == ST_TGT) && md_done && !cfg_inverted;
	assign md_start    = eval_tgt || eval_duty || tgt_to_rlen;

	// Operands for the shared unit.
	always_comb begin
		md_req = '0;
		priority if (eval_tgt) begin
			md_req.a = A_W'(spd_q);
			md_req.b = B_W'(DUTY_MAX);
			md_req.d = D_W'(POT_MAX);
		end else if (eval_duty) begin
			md_req.a = A_W'(target_q);
			md_req.b = elapsed[B_W-1:0];
			md_req.d = len_q;
		end else if (tgt_to_rlen) begin
			md_req.a = A_W'(rmp_q);
			md_req.b = cfg.ramp_max_ms - cfg.ramp_min_ms;
			md_req.d = D_W'(POT_MAX);
		end
	end

	msr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.req    (md_req),
		.done   (md_done),
		.q      (md_q)
	);

	// Sequencer and ramp state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			run_q    <= 1'b0;
			ramp_q   <= 1'b0;
			start_q  <= '0;
			target_q <= '0;
			len_q    <= LEN_W'(RAMP_LEN_RST);
			duty_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// The button event is applied before anything else.
						if (in_item.opcode == OP_STOP && run_q) begin
							run_q  <= 1'b0;
							duty_q <= '0;
						end else if (in_item.opcode == OP_START && !run_q) begin
							run_q   <= 1'b1;
							ramp_q  <= 1'b1;
							start_q <= in_item.now_ms;
						end
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (eval_tgt) begin
						state_q <= ST_TGT;
					end else if (eval_duty) begin
						state_q <= ST_DUTY;
					end else begin
						// Past the end of the ramp the duty holds at the target.
						if (run_q && ramp_q) begin
							ramp_q <= 1'b0;
							duty_q <= target_q;
						end
						state_q <= ST_DONE;
					end
				end
				ST_TGT: begin
					if (md_done) begin
						target_q <= md_q[DUTY_W-1:0];
						if (cfg_inverted) begin
							len_q   <= cfg.ramp_min_ms;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RLEN;
						end
					end
				end
				ST_RLEN: begin
					if (md_done) begin
						len_q   <= cfg.ramp_min_ms + md_q[LEN_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DUTY: begin
					if (md_done) begin
						duty_q  <= md_q[DUTY_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item fields held for the pass.
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_item.now_ms;
			spd_q <= spd_sat;
			rmp_q <= rmp_sat;
		end
	end

	// Result of the pass.
	assign res.pwm_duty = run_q ? duty_q : '0;
	assign res.running  = run_q;
	assign res.ramping  = run_q && ramp_q;

endmodule

/* rtl/motor_soft_start_ramp_top.sv */
// Soft-start ramp controller for a PWM-driven motor.
// Input stream (s_*): one item per control pass, carrying the button event,
// the millisecond time and the speed and ramp potentiometer readings.
// Output stream (m_*): exactly one item per input item, in order, with the
// PWM duty and the running and ramping flags after that pass.
// Configuration (APB): ramp_min_ms at address 0, ramp_max_ms at address 4.
// Write them only while no pass is in flight.
// Work per pass: no multiply-divide when running at a steady duty, one
// while ramping, two while stopped (target duty and ramp length; only one when
// ramp_max_ms is below ramp_min_ms and the length is simply ramp_min_ms).
// Each multiply-divide runs on one bit-serial unit: 10 multiply steps and 26
// restoring divide steps. One item is worked on at a time, so the next item
// waits until the current pass is done; a new item is taken while an earlier
// result still sits in the output register.
// Reset sets the registers to 1000 and 10000 ms, stops the motor and sets
// the ramp length to 1000 ms. When the receiver stalls, the result holds in
// the output register and the next pass waits to finish until it drains.
module motor_soft_start_ramp_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input item: opcode[1:0], now_ms[33:2], speed_pot[43:34], ramp_pot[53:44], zeros.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	// Result item: pwm_duty[7:0], running[8], ramping[9], zeros.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import msr_pkg::*;

	ramp_cfg_t  cfg_q;
	in_item_t   in_item;
	out_item_t  res;
	logic       res_valid;
	logic       res_ready;
	logic       m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic       cfg_wr;
	logic       reg_sel;

	// Unpack the input item.
	assign in_item.opcode    = s_tdata[1:0];
	assign in_item.now_ms    = s_tdata[33:2];
	assign in_item.speed_pot = s_tdata[43:34];
	assign in_item.ramp_pot  = s_tdata[53:44];

	// Configuration registers, word addressed.
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_min_ms <= REG_W'(RAMP_MIN_RST);
			cfg_q.ramp_max_ms <= REG_W'(RAMP_MAX_RST);
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_RAMP_MIN: cfg_q.ramp_min_ms <= pwdata[REG_W-1:0];
				REG_RAMP_MAX: cfg_q.ramp_max_ms <= pwdata[REG_W-1:0];
				default:      cfg_q.ramp_min_ms <= cfg_q.ramp_min_ms;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_RAMP_MIN: prdata = DATA_W'(cfg_q.ramp_min_ms);
			REG_RAMP_MAX: prdata = DATA_W'(cfg_q.ramp_max_ms);
			default:      prdata = '0;
		endcase
	end

	msr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register between the core and the receiver.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {6'b0, res.ramping, res.running, res.pwm_duty};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* sim/motor_soft_start_ramp_top_test.sv */
`timescale 1ns / 100ps

module motor_soft_start_ramp_top_test;

	import msr_pkg::*;

	// Spare button code; the block treats it as no event.
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 150;
	localparam int HOLD_CYCLES = 600;

	// Tracks the controller state and holds the results still to come.
	class duty_scoreboard;
		logic [REG_W-1:0]  min_ms;
		logic [REG_W-1:0]  max_ms;
		logic              run_on;
		logic              ramp_on;
		logic [TIME_W-1:0] t_start;
		logic [DUTY_W-1:0] duty_target;
		logic [DUTY_W-1:0] duty_now;
		logic [LEN_W-1:0]  len_ms;
		out_item_t         awaited[$];
		int                errors;

		function new();
			min_ms      = REG_W'(RAMP_MIN_RST);
			max_ms      = REG_W'(RAMP_MAX_RST);
			run_on      = 1'b0;
			ramp_on     = 1'b0;
			t_start     = '0;
			duty_target = '0;
			duty_now    = '0;
			len_ms      = LEN_W'(RAMP_LEN_RST);
			errors      = 0;
		endfunction

		function void set_reg(logic idx, logic [DATA_W-1:0] value);
			if (idx == REG_RAMP_MIN) begin
				min_ms = value[REG_W-1:0];
			end else begin
				max_ms = value[REG_W-1:0];
			end
		endfunction

		// Applies one control pass and queues the result it must produce.
		function void note_pass(in_item_t pass);
			longint unsigned spd, rmp, span, el, prod;
			out_item_t res;
			spd = pass.speed_pot;
			rmp = pass.ramp_pot;

			// The button event goes first.
			if (pass.opcode == OP_STOP && run_on) begin
				run_on   = 1'b0;
				duty_now = '0;
			end else if (pass.opcode == OP_START && !run_on) begin
				run_on  = 1'b1;
				ramp_on = 1'b1;
				t_start = pass.now_ms;
			end

			res.pwm_duty = '0;
			if (!run_on) begin
				// Stopped: follow the pots.
				duty_target = DUTY_W'(spd * DUTY_MAX / POT_MAX);
				if (max_ms < min_ms) begin
					len_ms = min_ms;
				end else begin
					span   = max_ms - min_ms;
					len_ms = LEN_W'(min_ms + rmp * span / POT_MAX);
				end
			end else begin
				// Running: rise linearly over the ramp length, then hold.
				if (ramp_on) begin
					el = TIME_W'(pass.now_ms - t_start);
					if (el <= len_ms) begin
						prod     = duty_target * el;
						duty_now = (len_ms == 0) ? '0 : DUTY_W'(prod / len_ms);
					end else begin
						ramp_on  = 1'b0;
						duty_now = duty_target;
					end
				end
				res.pwm_duty = duty_now;
			end
			res.running = run_on;
			res.ramping = run_on & ramp_on;
			awaited.push_back(res);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				$error("result with no pass waiting: duty %0d running %0b ramping %0b",
					got.pwm_duty, got.running, got.ramping);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.pwm_duty !== want.pwm_duty) begin
				$error("pwm_duty: expected %0d, got %0d", want.pwm_duty, got.pwm_duty);
				errors++;
			end
			if (got.running !== want.running) begin
				$error("running: expected %0b, got %0b", want.running, got.running);
				errors++;
			end
			if (got.ramping !== want.ramping) begin
				$error("ramping: expected %0b, got %0b", want.ramping, got.ramping);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	// Pass item: opcode[1:0], now_ms[33:2], speed_pot[43:34], ramp_pot[53:44], zeros.
	logic [55:0]       s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	// Result item: pwm_duty[7:0], running[8], ramping[9], zeros.
	logic [15:0]       m_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	duty_scoreboard sb = new();
	int             sent = 0;
	int             cycles = 0;
	logic           no_idle = 1'b0;
	logic           hold_req = 1'b0;

	motor_soft_start_ramp_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Check every result item as it is taken.
	always @(posedge clk) begin
		out_item_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.pwm_duty = m_tdata[7:0];
			got.running  = m_tdata[8];
			got.ramping  = m_tdata[9];
			sb.check_result(got);
		end
	end

	// Result side: random stalls per item, one long hold on request.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = HOLD_CYCLES;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 13);
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic [POT_W-1:0] pick_pot();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return POT_W'($urandom);
		endcase
	endfunction

	// Button codes that leave a stopped motor stopped.
	function automatic logic [OP_W-1:0] quiet_op();
		case ($urandom_range(0, 3))
			0: return OP_STOP;
			1: return OP_SPARE;
			default: return OP_NONE;
		endcase
	endfunction

	// Button codes during a run; a stop is rare so most ramps play out.
	function automatic logic [OP_W-1:0] run_op();
		case ($urandom_range(0, 19))
			0: return OP_STOP;
			1: return OP_START;
			2: return OP_SPARE;
			default: return OP_NONE;
		endcase
	endfunction

	// Offers one pass after a random gap and returns at the edge that takes it.
	task automatic send_pass(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
	                         input logic [POT_W-1:0] spd, input logic [POT_W-1:0] rmp);
		int gap;
		in_item_t pass;
		pass.opcode    = op;
		pass.now_ms    = t;
		pass.speed_pot = spd;
		pass.ramp_pot  = rmp;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {2'b00, rmp, spd, t, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_pass(pass);
		sent++;
	endtask

	task automatic apb_cycle(input logic wr, input logic idx, input logic [DATA_W-1:0] wdata,
	                         output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes a register with junk in the unused upper bits, then reads it back.
	task automatic write_reg(input logic idx, input logic [REG_W-1:0] value);
		logic [DATA_W-1:0] wdata;
		logic [DATA_W-1:0] rdata;
		wdata = {(DATA_W-REG_W)'($urandom), value};
		apb_cycle(1'b1, idx, wdata, rdata);
		sb.set_reg(idx, wdata);
		apb_cycle(1'b0, idx, '0, rdata);
		if (rdata[REG_W-1:0] !== value) begin
			$error("register %0d: expected %0d, got %0d", idx, value, rdata[REG_W-1:0]);
			sb.errors++;
		end
	endtask

	// Drops the pass stream and waits until every result has come back.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Stop if running, stopped passes, a start, passes with rising time; or random ones.
	task automatic ramp_cycle();
		logic [TIME_W-1:0] t;
		int n;
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 4))
				send_pass(OP_W'($urandom), $urandom, pick_pot(), pick_pot());
			return;
		end
		if (sb.run_on)
			send_pass(OP_STOP, $urandom, pick_pot(), pick_pot());
		repeat ($urandom_range(1, 3))
			send_pass(quiet_op(), $urandom, pick_pot(), pick_pot());
		if ($urandom_range(0, 3) == 0)
			t = 32'hFFFF_FFFF - $urandom_range(0, 70000);
		else
			t = $urandom;
		send_pass(OP_START, t, pick_pot(), pick_pot());
		n = $urandom_range(2, 16);
		repeat (n) begin
			t = t + TIME_W'($urandom_range(0, sb.len_ms / 3 + 2));
			if ($urandom_range(0, 15) == 0)
				t = $urandom;
			send_pass(run_op(), t, pick_pot(), pick_pot());
		end
	endtask

	// Directed passes with the reset settings: 1000 to 10000 ms.
	task automatic directed_passes();
		send_pass(OP_NONE, 32'h0000_0000, '1, '1);
		send_pass(OP_STOP, 32'hFFFF_FFFF, '0, '0);
		send_pass(OP_SPARE, 32'h1234_5678, '1, '0);
		// Start close to the wrap of the time counter; the pots must not count.
		send_pass(OP_START, 32'hFFFF_FE00, 10'h2AA, 10'h155);
		send_pass(OP_NONE, 32'hFFFF_FE00, 10'h155, 10'h2AA);
		send_pass(OP_START, 32'hFFFF_FFFF, '0, '0);
		// Elapsed time right at the ramp length, then one past it.
		send_pass(OP_NONE, 32'h0000_01E8, '0, '1);
		send_pass(OP_NONE, 32'h0000_01E9, '1, '0);
		send_pass(OP_SPARE, 32'h0000_0000, '0, '0);
		send_pass(OP_STOP, 32'h0000_0300, '1, '1);
		send_pass(OP_NONE, 32'd100, 10'h200, 10'h200);
		send_pass(OP_START, 32'd5000, '0, '0);
		send_pass(OP_NONE, 32'd5100, '0, '0);
		// A click during the ramp stops the motor while the ramp flag stays set.
		send_pass(OP_STOP, 32'd5200, '1, '1);
		send_pass(OP_NONE, 32'd5300, '1, '1);
		send_pass(OP_START, 32'd6000, '0, '0);
		send_pass(OP_NONE, 32'd9000, '0, '0);
		send_pass(OP_NONE, 32'd20000, '0, '0);
		send_pass(OP_STOP, 32'd20001, '0, '0);
	endtask

	initial begin
		logic [REG_W-1:0] lo_set[7];
		logic [REG_W-1:0] hi_set[7];
		int first;
		lo_set = '{16'd1, 16'd65535, 16'd1000, 16'd0, 16'd65535, 16'd1, 16'd0};
		hi_set = '{16'd65535, 16'd1, 16'd10000, 16'd0, 16'd65535, 16'd1, 16'd0};
		lo_set[6] = REG_W'($urandom);
		hi_set[6] = REG_W'($urandom);
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_passes();

		// Settings phases: wide span, inverted span, reset values without idling,
		// zero length with a long output hold, both at maximum, both at one, random.
		for (int ph = 0; ph < 7; ph++) begin
			settle();
			write_reg(REG_RAMP_MIN, lo_set[ph]);
			write_reg(REG_RAMP_MAX, hi_set[ph]);
			no_idle = (ph == 2);
			hold_req = (ph == 3);
			first = sent;
			while (sent - first < PHASE_ITEMS)
				ramp_cycle();
		end

		settle();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
